>>> sv/xrg_pkg.sv
// Shared types, constants and reset values for the xoshiro256++ range generator.
package xrg_pkg;

  // Field widths
  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = WordW / 2;
  localparam int unsigned ProdW   = 2 * WordW;
  localparam int unsigned NumWord = 4;

  // splitmix64 constants
  localparam logic [WordW-1:0] GoldenStep = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixMulA    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MixMulB    = 64'h94D0_49BB_1331_11EB;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegRangeMin = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRangeMax = 1'b1;

  // Operation codes
  localparam logic OpDraw   = 1'b0;
  localparam logic OpReseed = 1'b1;

  // Request and result payloads
  typedef struct packed {
    logic             operation;
    logic [WordW-1:0] seed_value;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] drawn_value;
    logic             degenerate_range;
  } rsp_t;

  // Multiplier operand B source
  typedef enum logic [1:0] {
    BselMixA  = 2'd0,
    BselMixB  = 2'd1,
    BselBound = 2'd2
  } bsel_e;

  // Result source
  typedef enum logic [1:0] {
    OutRange = 2'd0,
    OutRaw   = 2'd1,
    OutDegen = 2'd2
  } out_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       seed_load;
    logic       mix_add;
    logic       mix_b;
    logic       word_push;
    logic       draw_load;
    logic       mul_en;
    logic [1:0] mul_step;
    bsel_e      mul_bsel;
    logic       out_load;
    out_sel_e   out_sel;
    logic       advance;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic degenerate;
    logic full_range;
  } status_t;

  // splitmix64 output mixer, evaluated only at elaboration for reset values
  function automatic logic [WordW-1:0] mix64(input logic [WordW-1:0] acc);
    logic [WordW-1:0] z;
    z = acc;
    z = (z ^ (z >> 30)) * MixMulA;
    z = (z ^ (z >> 27)) * MixMulB;
    return z ^ (z >> 31);
  endfunction

  // State after reset: splitmix64 expansion of seed zero
  localparam logic [WordW-1:0] InitWord0 = mix64(64'(GoldenStep * 64'd1));
  localparam logic [WordW-1:0] InitWord1 = mix64(64'(GoldenStep * 64'd2));
  localparam logic [WordW-1:0] InitWord2 = mix64(64'(GoldenStep * 64'd3));
  localparam logic [WordW-1:0] InitWord3 = mix64(64'(GoldenStep * 64'd4));

endpackage

>>> sv/xoshiro256pp_range_generator_unit.sv
// Top level of the xoshiro256++ range generator.
// Draw requests return one 64-bit value in [range_min, range_max]; reseed requests
// reload the 256-bit state from four splitmix64 outputs and return nothing. One
// request is worked at a time, and all products go through a single shared 32x32
// multiplier, one partial product per cycle. A draw issues four partial products,
// drains the accumulator and loads the result; a full-range or degenerate draw
// goes straight to the result load. A reseed builds each state word from two
// 3-product multiplies, each followed by an accumulator drain, and three steps of
// adds and xor-shifts. The result register lets a finished result wait while the
// next request is accepted. The user must write the range registers through the
// write port only while the unit is idle; the block itself does not enforce this.
module xoshiro256pp_range_generator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  xrg_pkg::req_t                in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output xrg_pkg::rsp_t                out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [xrg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [xrg_pkg::WordW-1:0]    cfg_wdata_i
);
  import xrg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  xrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_req_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // State, multiplier and result
  xrg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .seed_i      (in_req_i.seed_value),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (out_rsp_o)
  );

endmodule

>>> sv/xrg_ctrl.sv
// Sequencing controller for the xoshiro256++ range generator.
module xrg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  xrg_pkg::status_t status_i,
  output xrg_pkg::cmd_t    cmd_o
);
  import xrg_pkg::*;

  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] StIdle   = 3'd0;
  localparam logic [StW-1:0] StMixAdd = 3'd1;
  localparam logic [StW-1:0] StMulA   = 3'd2;
  localparam logic [StW-1:0] StMixB   = 3'd3;
  localparam logic [StW-1:0] StMulB   = 3'd4;
  localparam logic [StW-1:0] StStore  = 3'd5;
  localparam logic [StW-1:0] StMulH   = 3'd6;
  localparam logic [StW-1:0] StResult = 3'd7;

  // Last issued partial product; a further count step drains the accumulator
  localparam logic [2:0] LowLast  = 3'd2;
  localparam logic [2:0] HighLast = 3'd3;

  logic [StW-1:0] state_q, state_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [1:0]     word_q, word_d;
  out_sel_e       sel_q, sel_d;
  logic           out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_bsel = BselMixA;
    cmd_o.out_sel  = sel_q;
    cmd_o.mul_step = cnt_q[1:0];
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cnt_d = '0;
          if (in_op_i == OpReseed) begin
            cmd_o.seed_load = 1'b1;
            word_d  = '0;
            state_d = StMixAdd;
          end else if (status_i.degenerate) begin
            sel_d   = OutDegen;
            state_d = StResult;
          end else if (status_i.full_range) begin
            cmd_o.draw_load = 1'b1;
            sel_d   = OutRaw;
            state_d = StResult;
          end else begin
            cmd_o.draw_load = 1'b1;
            sel_d   = OutRange;
            state_d = StMulH;
          end
        end
      end
      StMixAdd: begin
        cmd_o.mix_add = 1'b1;
        cnt_d   = '0;
        state_d = StMulA;
      end
      StMulA: begin
        cmd_o.mul_bsel = BselMixA;
        cmd_o.mul_en   = (cnt_q <= LowLast);
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == LowLast + 3'd1) begin
          state_d = StMixB;
        end
      end
      StMixB: begin
        cmd_o.mix_b = 1'b1;
        cnt_d   = '0;
        state_d = StMulB;
      end
      StMulB: begin
        cmd_o.mul_bsel = BselMixB;
        cmd_o.mul_en   = (cnt_q <= LowLast);
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == LowLast + 3'd1) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.word_push = 1'b1;
        word_d = word_q + 2'd1;
        if (word_q == 2'(NumWord - 1)) begin
          state_d = StIdle;
        end else begin
          state_d = StMixAdd;
        end
      end
      StMulH: begin
        cmd_o.mul_bsel = BselBound;
        cmd_o.mul_en   = (cnt_q <= HighLast);
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == HighLast + 3'd1) begin
          state_d = StResult;
        end
      end
      StResult: begin
        // Hold until the output register is free, then load, and advance unless the range is degenerate
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.advance  = (sel_q != OutDegen);
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      word_q      <= '0;
      sel_q       <= OutRange;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      word_q      <= word_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/xrg_datapath.sv
// Datapath: generator state, range registers, shared multiplier and result register.
module xrg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xrg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [xrg_pkg::WordW-1:0]     cfg_wdata_i,
  input  logic [xrg_pkg::WordW-1:0]     seed_i,
  input  xrg_pkg::cmd_t                 cmd_i,
  output xrg_pkg::status_t              status_o,
  output xrg_pkg::rsp_t                 rsp_o
);
  import xrg_pkg::*;

  logic [NumWord-1:0][WordW-1:0] word_q, word_d;
  logic [WordW-1:0] min_q, max_q;
  logic [WordW-1:0] seed_acc_q, seed_acc_d;
  logic [WordW-1:0] x_q, x_d;
  logic [WordW-1:0] bnd_q;
  logic [WordW-1:0] prod_q;
  logic [1:0]       prod_step_q;
  logic             prod_vld_q;
  logic [ProdW-1:0] acc_q, acc_add;
  rsp_t             rsp_q;

  logic [WordW-1:0] raw;
  logic [WordW-1:0] sum03;
  logic [WordW-1:0] acc_lo;
  logic [WordW-1:0] b_op;
  logic [HalfW-1:0] a_half, b_half;
  logic [WordW-1:0] t17, s2x, s3x, s1x, s0x;

  // Range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRangeMin: min_q <= cfg_wdata_i;
        RegRangeMax: max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign status_o.degenerate = (min_q >= max_q);
  assign status_o.full_range = (min_q == '0) && (max_q == '1);

  // Raw xoshiro256++ output
  assign sum03 = word_q[0] + word_q[3];
  assign raw   = ((sum03 << 23) | (sum03 >> (WordW - 23))) + word_q[0];

  assign acc_lo     = acc_q[WordW-1:0];
  assign seed_acc_d = seed_acc_q + GoldenStep;

  // Operand register: raw output, splitmix stage inputs
  always_comb begin
    x_d = x_q;
    if (cmd_i.draw_load) begin
      x_d = raw;
    end else if (cmd_i.mix_add) begin
      x_d = seed_acc_d ^ (seed_acc_d >> 30);
    end else if (cmd_i.mix_b) begin
      x_d = acc_lo ^ (acc_lo >> 27);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (cmd_i.seed_load) begin
      seed_acc_q <= seed_i;
    end else if (cmd_i.mix_add) begin
      seed_acc_q <= seed_acc_d;
    end
    if (cmd_i.draw_load) begin
      bnd_q <= 64'(max_q - min_q + 64'd1);
    end
  end

  // Shared 32x32 multiplier, one partial product per cycle
  always_comb begin
    case (cmd_i.mul_bsel)
      BselMixA:  b_op = MixMulA;
      BselMixB:  b_op = MixMulB;
      BselBound: b_op = bnd_q;
      default:   b_op = bnd_q;
    endcase
  end

  assign a_half = cmd_i.mul_step[1] ? x_q[WordW-1:HalfW] : x_q[HalfW-1:0];
  assign b_half = cmd_i.mul_step[0] ? b_op[WordW-1:HalfW] : b_op[HalfW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q      <= WordW'(a_half) * WordW'(b_half);
      prod_step_q <= cmd_i.mul_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  // Align the partial product and accumulate
  always_comb begin
    case (prod_step_q)
      2'd0:    acc_add = {{WordW{1'b0}}, prod_q};
      2'd3:    acc_add = {prod_q, {WordW{1'b0}}};
      default: acc_add = {{HalfW{1'b0}}, prod_q, {HalfW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      acc_q <= ((prod_step_q == 2'd0) ? {ProdW{1'b0}} : acc_q) + acc_add;
    end
  end

  // State update: xoshiro256 advance or splitmix word push
  assign t17 = word_q[1] << 17;
  assign s2x = word_q[2] ^ word_q[0];
  assign s3x = word_q[3] ^ word_q[1];
  assign s1x = word_q[1] ^ s2x;
  assign s0x = word_q[0] ^ s3x;

  always_comb begin
    word_d = word_q;
    if (cmd_i.advance) begin
      word_d[0] = s0x;
      word_d[1] = s1x;
      word_d[2] = s2x ^ t17;
      word_d[3] = (s3x << 45) | (s3x >> (WordW - 45));
    end else if (cmd_i.word_push) begin
      word_d[0] = word_q[1];
      word_d[1] = word_q[2];
      word_d[2] = word_q[3];
      word_d[3] = acc_lo ^ (acc_lo >> 31);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q[0] <= InitWord0;
      word_q[1] <= InitWord1;
      word_q[2] <= InitWord2;
      word_q[3] <= InitWord3;
    end else begin
      word_q <= word_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        OutRaw: begin
          rsp_q.drawn_value      <= x_q;
          rsp_q.degenerate_range <= 1'b0;
        end
        OutDegen: begin
          rsp_q.drawn_value      <= min_q;
          rsp_q.degenerate_range <= 1'b1;
        end
        default: begin
          rsp_q.drawn_value      <= min_q + acc_q[ProdW-1:WordW];
          rsp_q.degenerate_range <= 1'b0;
        end
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule
